// File: sv/srf_pkg.sv
// srf_pkg: shared constants, types and the arctangent table of the sector range filter
// no dependencies; used by sector_range_filter_top and tb

package srf_pkg;

    // parameter defaults
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // fixed field widths
    localparam int FIELD_W  = 16;
    localparam int SIZE_W   = 12;
    localparam int SPREAD_W = 17;
    localparam int INDEX_W  = 3;

    // datapath widths: cordic vector lanes and angle accumulator (2^32 per turn)
    localparam int VEC_W = 60;
    localparam int ANG_W = 34;

    // quarter turn in accumulator units
    localparam logic signed [ANG_W-1:0] QUARTER = 34'sh0_4000_0000;

    // register indexes
    typedef enum logic [INDEX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_REACH    = 3'd2,
        REG_FACING   = 3'd3,
        REG_SPREAD   = 3'd4
    } t_reg_index;

    // per-item side information travelling with the cordic lanes
    typedef struct packed {
        logic                near;
        logic                dzero;
        logic                szero;
        logic [FIELD_W-1:0]  bearing;
    } t_side;

    // atan(2^-i), 2^32 units per turn, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        begin
            case (idx)
                5'd0:  v = 34'sh0_2000_0000;
                5'd1:  v = 34'sh0_12E4_051E;
                5'd2:  v = 34'sh0_09FB_385B;
                5'd3:  v = 34'sh0_0511_11D4;
                5'd4:  v = 34'sh0_028B_0D43;
                5'd5:  v = 34'sh0_0145_D7E1;
                5'd6:  v = 34'sh0_00A2_F61E;
                5'd7:  v = 34'sh0_0051_7C55;
                5'd8:  v = 34'sh0_0028_BE53;
                5'd9:  v = 34'sh0_0014_5F2F;
                5'd10: v = 34'sh0_000A_2F98;
                5'd11: v = 34'sh0_0005_17CC;
                5'd12: v = 34'sh0_0002_8BE6;
                5'd13: v = 34'sh0_0001_45F3;
                5'd14: v = 34'sh0_0000_A2FA;
                5'd15: v = 34'sh0_0000_517D;
                5'd16: v = 34'sh0_0000_28BE;
                5'd17: v = 34'sh0_0000_145F;
                5'd18: v = 34'sh0_0000_0A30;
                5'd19: v = 34'sh0_0000_0518;
                5'd20: v = 34'sh0_0000_028C;
                5'd21: v = 34'sh0_0000_0146;
                5'd22: v = 34'sh0_0000_00A3;
                5'd23: v = 34'sh0_0000_0051;
                5'd24: v = 34'sh0_0000_0029;
                5'd25: v = 34'sh0_0000_0014;
                5'd26: v = 34'sh0_0000_000A;
                5'd27: v = 34'sh0_0000_0005;
                5'd28: v = 34'sh0_0000_0003;
                5'd29: v = 34'sh0_0000_0001;
                5'd30: v = 34'sh0_0000_0001;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: sv/sector_range_filter_top.sv
// sector_range_filter_top: pipelined sector test for round objects
// depends on srf_pkg (widths, register indexes, side struct, atan table)
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------------------
//  item in   | in        | i_start / o_busy       | i_obj_x, i_obj_y, i_obj_size
//  result    | out       | o_done strobe          | o_in_region
//  config    | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  one item per cycle; o_busy is never raised, so start may be high every cycle
//  pipeline: two cordic chains of CORDIC_STEPS stages each
//  (bearing/magnitude, then half-size angle) behind two input stages, one output stage
//  synchronous active-low reset clears the valid bits and the registers to their defaults
//  results show for one cycle on o_done; the receiver has no way to stall the pipeline

module sector_range_filter_top #(
    parameter int COORD_WIDTH  = srf_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = srf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [srf_pkg::FIELD_W-1:0]   i_obj_x,
    input  logic [srf_pkg::FIELD_W-1:0]   i_obj_y,
    input  logic [srf_pkg::SIZE_W-1:0]    i_obj_size,
    output logic                          o_done,
    output logic                          o_in_region,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [srf_pkg::INDEX_W-1:0]   i_cfg_index,
    input  logic [srf_pkg::SPREAD_W-1:0]  i_cfg_data
);

    localparam int UW        = (COORD_WIDTH < srf_pkg::FIELD_W) ? COORD_WIDTH
                                                                : srf_pkg::FIELD_W;
    localparam int PRE_SHIFT = (COORD_WIDTH > 12) ? (55 - COORD_WIDTH) : 43;
    localparam int N         = CORDIC_STEPS;
    localparam int CW        = srf_pkg::VEC_W;
    localparam int ZW        = srf_pkg::ANG_W;
    localparam int FW        = srf_pkg::FIELD_W;
    localparam int SW        = srf_pkg::SIZE_W;
    localparam int PW        = srf_pkg::SPREAD_W;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic [FW-1:0] r_center_x, r_center_y, r_reach, r_facing;
    logic [PW-1:0] r_spread;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_reach    <= '0;
            r_facing   <= '0;
            r_spread   <= PW'(1) << FW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                srf_pkg::REG_CENTER_X: r_center_x <= i_cfg_data[FW-1:0];
                srf_pkg::REG_CENTER_Y: r_center_y <= i_cfg_data[FW-1:0];
                srf_pkg::REG_REACH:    r_reach    <= i_cfg_data[FW-1:0];
                srf_pkg::REG_FACING:   r_facing   <= i_cfg_data[FW-1:0];
                srf_pkg::REG_SPREAD:   r_spread   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: absolute differences and signs
    logic [UW-1:0] c_ox, c_oy, c_cx, c_cy;
    logic          r0_v;
    logic [UW-1:0] r0_ax, r0_ay;
    logic          r0_negx, r0_negy;
    logic [SW-1:0] r0_sz;

    assign c_ox = i_obj_x[UW-1:0];
    assign c_oy = i_obj_y[UW-1:0];
    assign c_cx = r_center_x[UW-1:0];
    assign c_cy = r_center_y[UW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= i_start;
        end
        r0_ax   <= (c_ox >= c_cx) ? c_ox - c_cx : c_cx - c_ox;
        r0_ay   <= (c_oy >= c_cy) ? c_oy - c_cy : c_cy - c_oy;
        r0_negx <= c_ox < c_cx;
        r0_negy <= c_oy < c_cy;
        r0_sz   <= i_obj_size;
    end

    // stage 1: squares, cordic lane set-up with quadrant pre-rotation
    logic [2*UW-1:0]        r1_sqx, r1_sqy, r1_rr;
    logic [2*SW-1:0]        r1_szsq;
    logic signed [CW-1:0]   c_mx, c_my, c_dx, c_dy;
    logic signed [CW-1:0]   n_px, n_py;
    logic signed [ZW-1:0]   n_pz;
    logic [UW-1:0]          c_r;

    assign c_r  = r_reach[UW-1:0];
    assign c_mx = $signed(CW'(r0_ax)) <<< PRE_SHIFT;
    assign c_my = $signed(CW'(r0_ay)) <<< PRE_SHIFT;
    assign c_dx = r0_negx ? -c_mx : c_mx;
    assign c_dy = r0_negy ? -c_my : c_my;

    always_comb begin
        n_px = c_dx;
        n_py = c_dy;
        n_pz = '0;
        if (c_dx[CW-1]) begin
            if (!c_dy[CW-1]) begin
                n_px = c_dy;
                n_py = -c_dx;
                n_pz = srf_pkg::QUARTER;
            end else begin
                n_px = -c_dy;
                n_py = c_dx;
                n_pz = -srf_pkg::QUARTER;
            end
        end
    end

    // cordic chain a: vector lane (x, y, z) and size lane (gx, gy)
    logic                  a_v  [0:N];
    logic signed [CW-1:0]  a_x  [0:N];
    logic signed [CW-1:0]  a_y  [0:N];
    logic signed [ZW-1:0]  a_z  [0:N];
    logic signed [CW-1:0]  a_gx [0:N];
    logic signed [CW-1:0]  a_gy [0:N];
    logic                  a_dz [0:N];
    logic                  a_sz [0:N];
    srf_pkg::t_side        a_s  [1:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            a_v[0] <= 1'b0;
        end else begin
            a_v[0] <= r0_v;
        end
        r1_sqx  <= r0_ax * r0_ax;
        r1_sqy  <= r0_ay * r0_ay;
        r1_rr   <= c_r * c_r;
        r1_szsq <= r0_sz * r0_sz;
        a_x[0]  <= n_px;
        a_y[0]  <= n_py;
        a_z[0]  <= n_pz;
        a_gx[0] <= $signed(CW'(r0_sz)) <<< PRE_SHIFT;
        a_gy[0] <= '0;
        a_dz[0] <= (r0_ax == '0) && (r0_ay == '0);
        a_sz[0] <= r0_sz == '0;
    end

    // squared-distance test, taken into the side info at the first cordic step
    logic c_near;
    assign c_near = ({1'b0, r1_sqx} + {1'b0, r1_sqy})
                 <= ({1'b0, r1_rr} + (2*UW+1)'(r1_szsq));

    for (genvar k = 0; k < N; k++) begin : g_stage_a
        logic signed [CW-1:0] c_xs, c_ys, c_gxs, c_gys;
        logic                 c_up, c_gup;
        assign c_xs  = a_x[k] >>> k;
        assign c_ys  = a_y[k] >>> k;
        assign c_gxs = a_gx[k] >>> k;
        assign c_gys = a_gy[k] >>> k;
        assign c_up  = !a_y[k][CW-1] && (a_y[k] != '0);
        assign c_gup = !a_gy[k][CW-1] && (a_gy[k] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                a_v[k+1] <= 1'b0;
            end else begin
                a_v[k+1] <= a_v[k];
            end
            a_x[k+1]  <= c_up ? a_x[k] + c_ys : a_x[k] - c_ys;
            a_y[k+1]  <= c_up ? a_y[k] - c_xs : a_y[k] + c_xs;
            a_z[k+1]  <= c_up ? a_z[k] + srf_pkg::atan_entry(5'(k))
                              : a_z[k] - srf_pkg::atan_entry(5'(k));
            a_gx[k+1] <= c_gup ? a_gx[k] + c_gys : a_gx[k] - c_gys;
            a_gy[k+1] <= c_gup ? a_gy[k] - c_gxs : a_gy[k] + c_gxs;
            a_dz[k+1] <= a_dz[k];
            a_sz[k+1] <= a_sz[k];
            if (k == 0) begin
                a_s[k+1].near <= c_near;
            end else begin
                a_s[k+1].near <= a_s[(k == 0) ? 1 : k].near;
            end
            a_s[k+1].dzero   <= 1'b0;
            a_s[k+1].szero   <= 1'b0;
            a_s[k+1].bearing <= '0;
        end
    end

    // bearing in binary angle units, round half up
    logic [ZW-1:0] c_zr;
    assign c_zr = $unsigned(a_z[N]) + ZW'(32'h8000);

    // cordic chain b: angle of (|d|, size) in gain-scaled units
    logic                  b_v [0:N];
    logic signed [CW-1:0]  b_x [0:N];
    logic signed [CW-1:0]  b_y [0:N];
    logic signed [ZW-1:0]  b_z [0:N];
    srf_pkg::t_side        b_s [0:N];

    assign b_v[0]         = a_v[N];
    assign b_x[0]         = a_x[N];
    assign b_y[0]         = a_gx[N];
    assign b_z[0]         = '0;
    assign b_s[0].near    = a_s[N].near;
    assign b_s[0].dzero   = a_dz[N];
    assign b_s[0].szero   = a_sz[N];
    assign b_s[0].bearing = a_dz[N] ? '0 : c_zr[31:16];

    for (genvar k = 0; k < N; k++) begin : g_stage_b
        logic signed [CW-1:0] c_xs, c_ys;
        logic                 c_up;
        assign c_xs = b_x[k] >>> k;
        assign c_ys = b_y[k] >>> k;
        assign c_up = !b_y[k][CW-1] && (b_y[k] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                b_v[k+1] <= 1'b0;
            end else begin
                b_v[k+1] <= b_v[k];
            end
            b_x[k+1] <= c_up ? b_x[k] + c_ys : b_x[k] - c_ys;
            b_y[k+1] <= c_up ? b_y[k] - c_xs : b_y[k] + c_xs;
            b_z[k+1] <= c_up ? b_z[k] + srf_pkg::atan_entry(5'(k))
                             : b_z[k] - srf_pkg::atan_entry(5'(k));
            b_s[k+1] <= b_s[k];
        end
    end

    // output stage: half-size, circular difference, sector decision
    logic [ZW:0]   c_hr;
    logic [PW-1:0] c_half;
    logic [FW-1:0] c_d;
    logic [PW-1:0] c_circ;
    logic          c_full, n_hit;

    assign c_hr   = {1'b0, $unsigned(b_z[N])} + (ZW+1)'(32'h8000);
    assign c_half = (b_s[N].szero || b_z[N][ZW-1]) ? '0 : c_hr[32:16];
    assign c_d    = r_facing - b_s[N].bearing;
    assign c_circ = (c_d > FW'(32768)) ? (PW'(1) << FW) - PW'(c_d) : PW'(c_d);
    assign c_full = r_spread >= (PW'(1) << FW);

    always_comb begin
        if (c_full) begin
            n_hit = b_s[N].near;
        end else if (r_spread != '0 && b_s[N].near) begin
            n_hit = {1'b0, c_circ} < ({1'b0, r_spread} + {1'b0, c_half});
        end else begin
            n_hit = 1'b0;
        end
    end

    logic r_done, r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_done <= b_v[N];
            r_hit  <= b_v[N] & n_hit;
        end
    end

    assign o_done      = r_done;
    assign o_in_region = r_hit;

    // checks
    a_hit_only_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_region |-> o_done) else $error("hit without result strobe");

    a_done_follows_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_v[N] |=> o_done) else $error("result strobe lost at output stage");

    a_far_never_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_v[N] && !b_s[N].near) |=> !o_in_region)
        else $error("object outside reach reported as hit");

    a_zero_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_v[N] && r_spread == '0) |=> !o_in_region)
        else $error("zero spread reported a hit");

endmodule

// File: bench/tb.sv
// tb: self-checking bench for sector_range_filter_top, with its own sector predictor
// depends on srf_pkg (field widths, parameter defaults, register indexes) and sector_range_filter_top

module tb;

    localparam int  LATENCY    = 2 * srf_pkg::CORDIC_STEPS_DEF + 3;
    localparam int  STALL_MAX  = 4000;
    localparam int  PRE_SHIFT  = 55 - srf_pkg::COORD_WIDTH_DEF;
    localparam int  RAND_ITEMS = 1080;

    typedef struct {
        logic [srf_pkg::FIELD_W-1:0] x;
        logic [srf_pkg::FIELD_W-1:0] y;
        logic [srf_pkg::SIZE_W-1:0]  size;
    } t_obj;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_start = 1'b0;
    logic                         o_busy;
    logic [srf_pkg::FIELD_W-1:0]  i_obj_x = '0;
    logic [srf_pkg::FIELD_W-1:0]  i_obj_y = '0;
    logic [srf_pkg::SIZE_W-1:0]   i_obj_size = '0;
    logic                         o_done;
    logic                         o_in_region;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [srf_pkg::INDEX_W-1:0]  i_cfg_index = '0;
    logic [srf_pkg::SPREAD_W-1:0] i_cfg_data = '0;

    // local copy of the sector settings
    logic [15:0] cen_x, cen_y, reach, facing_q;
    logic [16:0] spread_q;

    t_obj   pending_objs[$];
    logic   expected_hits[$];
    logic   acc_q = 1'b0;
    logic   no_idle = 1'b0;
    int     errors = 0;
    int     stall_cnt = 0;

    // atan(2^-i), 2^32 per turn
    longint atan_lut[16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    sector_range_filter_top u_top (.*);

    always #10 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // vectoring rotation: gain-scaled magnitude and angle of (xi, yi)
    function automatic void vector_rotate(input longint xi, input longint yi,
                                          output longint mag, output longint ang);
        longint x, y, z, t, xs, ys;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            ang = 0;
            return;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(1) <<< 30;
            end else begin
                x = -y;
                y = t;
                z = -(longint'(1) <<< 30);
            end
        end
        for (int i = 0; i < srf_pkg::CORDIC_STEPS_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += atan_lut[i];
            end else begin
                x -= ys;
                y += xs;
                z -= atan_lut[i];
            end
        end
        mag = x;
        ang = z;
    endfunction

    // does the round object touch the configured sector
    function automatic logic sector_hit(input t_obj o);
        longint ax, ay, dx, dy, scale, mag, ang, smag, hang, dummy;
        longint bearing, half, d, circ;
        logic   near;
        ax = (o.x >= cen_x) ? longint'(o.x) - cen_x : longint'(cen_x) - o.x;
        ay = (o.y >= cen_y) ? longint'(o.y) - cen_y : longint'(cen_y) - o.y;
        near = (ax * ax + ay * ay) <= (longint'(reach) * reach + longint'(o.size) * o.size);
        if (spread_q[16])
            return near;
        if (spread_q == 0 || !near)
            return 1'b0;
        scale = longint'(1) <<< PRE_SHIFT;
        dx = ((o.x >= cen_x) ? ax : -ax) * scale;
        dy = ((o.y >= cen_y) ? ay : -ay) * scale;
        vector_rotate(dx, dy, mag, ang);
        bearing = (ax == 0 && ay == 0) ? 0 : (((ang + 'h8000) >>> 16) & 'hFFFF);
        vector_rotate(longint'(o.size) * scale, 0, smag, dummy);
        vector_rotate(mag, smag, dummy, hang);
        if (o.size == 0 || hang < 0)
            half = 0;
        else
            half = ((hang + 'h8000) >>> 16) & 'h1FFFF;
        d = (longint'(facing_q) - bearing) & 'hFFFF;
        circ = (d > 32768) ? 65536 - d : d;
        return circ < (longint'(spread_q) + half);
    endfunction

    // item driver, changes on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_start || acc_q)) begin
            if (pending_objs.size() > 0 && (no_idle || $urandom_range(99) >= 15)) begin
                t_obj o;
                o = pending_objs.pop_front();
                i_obj_x <= o.x;
                i_obj_y <= o.y;
                i_obj_size <= o.size;
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: predict on accept, check on strobe
    always @(posedge i_clk) begin
        logic want;
        t_obj o;
        acc_q <= i_start && !o_busy && i_rst_n;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_hits.size() == 0) begin
                    report("result with none expected");
                end else begin
                    want = expected_hits.pop_front();
                    if (o_in_region !== want)
                        report($sformatf("in_region %b, expected %b", o_in_region, want));
                end
            end
            if (i_start && !o_busy) begin
                o.x = i_obj_x;
                o.y = i_obj_y;
                o.size = i_obj_size;
                expected_hits = {expected_hits, sector_hit(o)};
            end
        end
    end

    // watchdog on cycles with nothing moving
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input srf_pkg::t_reg_index idx, input logic [16:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            srf_pkg::REG_CENTER_X: cen_x = val[15:0];
            srf_pkg::REG_CENTER_Y: cen_y = val[15:0];
            srf_pkg::REG_REACH:    reach = val[15:0];
            srf_pkg::REG_FACING:   facing_q = val[15:0];
            srf_pkg::REG_SPREAD:   spread_q = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        wait (pending_objs.size() == 0 && !i_start && expected_hits.size() == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic set_sector(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] r, input logic [15:0] f,
                              input logic [16:0] s);
        write_reg(srf_pkg::REG_CENTER_X, cx);
        write_reg(srf_pkg::REG_CENTER_Y, cy);
        write_reg(srf_pkg::REG_REACH, r);
        write_reg(srf_pkg::REG_FACING, f);
        write_reg(srf_pkg::REG_SPREAD, s);
    endtask

    task automatic add_obj(input logic [15:0] x, input logic [15:0] y, input logic [11:0] s);
        t_obj o;
        o.x = x;
        o.y = y;
        o.size = s;
        pending_objs = {pending_objs, o};
    endtask

    // mostly objects around the centre, some anywhere
    task automatic add_random_objs(input int n);
        int span;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 20) begin
                add_obj(16'($urandom), 16'($urandom), 12'($urandom));
            end else begin
                span = int'(reach) + int'(reach) / 4 + 8;
                add_obj(16'(int'(cen_x) + int'($urandom_range(2 * span)) - span),
                        16'(int'(cen_y) + int'($urandom_range(2 * span)) - span),
                        ($urandom_range(3) == 0) ? 12'($urandom)
                                                 : 12'($urandom_range(64)));
            end
        end
    endtask

    initial begin
        logic [16:0] spr;
        cen_x = '0;
        cen_y = '0;
        reach = '0;
        facing_q = '0;
        spread_q = 17'h10000;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: full circle around the origin
        add_obj(0, 0, 0);
        add_obj(0, 0, 4095);
        add_obj(65535, 65535, 4095);
        add_obj(3000, 2000, 4095);
        drain();

        // narrow sector with special cases
        set_sector(32768, 32768, 40000, 0, 8192);
        add_obj(32768, 32768, 0);
        add_obj(32768, 32768, 100);
        add_obj(40000, 32768, 0);
        add_obj(32768, 40000, 0);
        add_obj(20000, 32768, 4095);
        add_obj(32768, 20000, 50);
        add_obj(65535, 65535, 4095);
        add_obj(0, 0, 4095);
        add_obj(65535, 0, 0);
        add_obj(0, 65535, 0);
        add_obj(33000, 32770, 4000);
        drain();

        // zero spread, spread above a full turn, unused register indexes
        set_sector(100, 65435, 65535, 65535, 0);
        add_obj(200, 65000, 10);
        add_obj(100, 65435, 0);
        drain();
        write_reg(srf_pkg::t_reg_index'(3'd5), 17'h1FFFF);
        write_reg(srf_pkg::t_reg_index'(3'd7), 17'h0);
        write_reg(srf_pkg::REG_SPREAD, 17'h1FFFF);
        add_obj(0, 65535, 4095);
        add_obj(65535, 0, 0);
        add_obj(300, 65000, 7);
        drain();

        // random phases, one with no idling at all
        for (int p = 0; p < 12; p++) begin
            case ($urandom_range(5))
                0: spr = 17'h10000;
                1: spr = 17'd1;
                2: spr = 17'hFFFF;
                3: spr = 17'd0;
                default: spr = 17'($urandom_range(16384));
            endcase
            set_sector(16'($urandom), 16'($urandom),
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000)),
                       ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom), spr);
            no_idle = (p == 5);
            add_random_objs(RAND_ITEMS / 12);
            drain();
        end
        no_idle = 1'b0;

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
